@@ rtl/core/cosine_top_k_vector_search_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the cosine top-k vector search
// Shared property forms. They expect clk and arst_n in scope.
// ---------------------------------------------------------------------------
`ifndef COSINE_TOP_K_VECTOR_SEARCH_ASSERT_SVH
`define COSINE_TOP_K_VECTOR_SEARCH_ASSERT_SVH

// same-cycle implication
`define CTKVS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTKVS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/ctkvs_pkg.sv @@
// ---------------------------------------------------------------------------
// ctkvs_pkg
// Sizes, codes and state encoding of the cosine top-k vector search.
// ---------------------------------------------------------------------------
package ctkvs_pkg;

	localparam int MAX_ENTRIES = 256;
	localparam int MAX_DIM     = 64;
	localparam int MAX_K       = 16;
	localparam int ELEM_W      = 16;

	localparam int COLL_W = 3;
	localparam int K_W    = 5;
	localparam int IDX_W  = 8;
	localparam int STAT_W = 3;

	localparam int ENT_W  = $clog2(MAX_ENTRIES);
	localparam int DIM_W  = $clog2(MAX_DIM);
	localparam int LEN_W  = $clog2(MAX_DIM + 1);
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int BC_W   = $clog2(MAX_K + 1);
	localparam int META_W = LEN_W + COLL_W;
	localparam int VEC_AW = ENT_W + DIM_W;

	// accumulators hold a sum of MAX_DIM products
	localparam int ACC_W  = 2 * ELEM_W + DIM_W;
	localparam int PROD_W = 2 * ACC_W;
	localparam int MC_W   = $clog2(ACC_W);
	// Q1.15 scale squared
	localparam int RSH    = 2 * (ELEM_W - 1);
	localparam int ROOT_W = ELEM_W;
	localparam int J_W    = $clog2(ROOT_W);
	localparam int WIDE_W = PROD_W + 2 * ELEM_W + 2;
	localparam int SCORE_MAX = 2 ** (ELEM_W - 1) - 1;

	typedef enum logic [STAT_W-1:0] {
		STAT_INSERTED = 3'd0,
		STAT_MATCH    = 3'd1,
		STAT_NO_MATCH = 3'd2,
		STAT_FULL     = 3'd3,
		STAT_TOO_LONG = 3'd4,
		STAT_DISABLED = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_META,
		ST_META_W,
		ST_MAC_RD,
		ST_MAC_M0,
		ST_MAC_M1,
		ST_MAC_M2,
		ST_MAC_M3,
		ST_NORM,
		ST_MUL,
		ST_ROOT_A,
		ST_ROOT_B,
		ST_SCORE,
		ST_INSERT,
		ST_DONE,
		ST_EMIT
	} state_t;

endpackage

@@ rtl/core/ctkvs_ram.sv @@
// ---------------------------------------------------------------------------
// ctkvs_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module ctkvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ rtl/core/cosine_top_k_vector_search.sv @@
// ---------------------------------------------------------------------------
// cosine_top_k_vector_search
// Vector store with brute-force cosine scoring and top-k selection.
// ---------------------------------------------------------------------------
// Vectors stream in one element per input beat; last_element closes a vector.
// An insert vector lands in the next free entry (up to 256 entries of up to 64
// elements) and one beat comes back with its entry index. A query vector is
// scored against every stored vector of the same collection and length, and
// the best result_limit (at most 16) come back in descending score order, ties
// to the lower entry, the last beat flagged by last_result. Status codes:
// inserted, match, no match, store full, vector too long, not enabled.
// Non-last elements and insert ends are handled in the idle state. A query
// end walks the entries: a non-matching entry needs only its metadata read,
// and a matching entry is scored with the one shared 16x16 multiplier that
// does three products per element, the bit-serial shift-add unit forming the
// norm product and the squared dot product, and the bit-by-bit root search.
// Result beats follow at one per cycle while result_ready is high. No new
// item is taken until the last result beat is registered.
// port_enabled resets low; while low every item returns a not-enabled beat and
// any partly streamed vector is dropped. Stored vectors have no reset.
// ---------------------------------------------------------------------------
`include "cosine_top_k_vector_search_assert.svh"

module cosine_top_k_vector_search
	import ctkvs_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	// config
	input  logic                     cfg_write,
	input  logic                     cfg_data,
	// input beats
	input  logic                     item_valid,
	output logic                     item_ready,
	input  logic                     operation,
	input  logic [COLL_W-1:0]        collection_id,
	input  logic signed [ELEM_W-1:0] element_value,
	input  logic                     last_element,
	input  logic [K_W-1:0]           result_limit,
	// result beats
	output logic                     result_valid,
	input  logic                     result_ready,
	output logic [STAT_W-1:0]        status,
	output logic [IDX_W-1:0]         entry_index,
	output logic signed [ELEM_W-1:0] similarity,
	output logic                     last_result
);

	// control state
	state_t             state_q, state_d;
	logic               port_en_q;
	logic [CNT_W-1:0]   entry_cnt_q;
	logic [LEN_W-1:0]   elem_cnt_q;
	logic               ovf_q;
	logic [BC_W-1:0]    bc_q;

	// query context
	logic [COLL_W-1:0]  coll_q;
	logic [LEN_W-1:0]   len_q;
	logic [BC_W-1:0]    k_q;
	logic [CNT_W-1:0]   e_q;
	logic [LEN_W-1:0]   i_q;

	// dot product and norms
	logic signed [ACC_W-1:0]    dot_q;
	logic [ACC_W-1:0]           na_q, nb_q;
	logic signed [2*ELEM_W-1:0] prod_q;
	logic                       neg_q;

	// bit-serial multiplier
	logic [PROD_W-1:0]  ma_q, macc_q, macc_nx, p_q;
	logic [ACC_W-1:0]   mb_q, mag;
	logic [MC_W-1:0]    mcnt_q;
	logic               mphase_q;

	// root search: largest x with x^2 * P <= R
	logic [WIDE_W-1:0]  r_q, s_q, tj_q, pj_q, cand_q;
	logic [ROOT_W-1:0]  x_q, sat;
	logic [J_W-1:0]     j_q;
	logic signed [ELEM_W-1:0] score_q;

	// top-k list, slot 0 best
	logic [ENT_W-1:0]         best_idx_q   [MAX_K];
	logic signed [ELEM_W-1:0] best_score_q [MAX_K];
	logic [MAX_K-1:0]         gt;
	logic [BC_W-1:0]          ins_pos;
	logic                     ins_ok;

	// stores
	logic                     vec_we, q_we, meta_we, meta_re, mac_re;
	logic [ELEM_W-1:0]        vec_rd, q_rd;
	logic [META_W-1:0]        meta_rd;

	// element bookkeeping
	logic               fire, room, full;
	logic [LEN_W-1:0]   len_new;
	logic               ovf_new;

	// shared multiplier
	logic signed [ELEM_W-1:0]   mul_a, mul_b;
	logic signed [2*ELEM_W-1:0] mul_p;

	// result register
	logic               out_free, emit, emit_last;
	status_t            emit_status;
	logic [IDX_W-1:0]   emit_idx;
	logic signed [ELEM_W-1:0] emit_sim;

	assign fire     = item_valid && item_ready;
	assign out_free = !result_valid || result_ready;
	assign room     = elem_cnt_q < LEN_W'(MAX_DIM);
	assign full     = entry_cnt_q >= CNT_W'(MAX_ENTRIES);
	assign len_new  = room ? elem_cnt_q + LEN_W'(1) : elem_cnt_q;
	assign ovf_new  = ovf_q || !room;

	assign vec_we  = fire && port_en_q && room && !operation && !full;
	assign q_we    = fire && port_en_q && room && operation;
	assign meta_we = fire && port_en_q && last_element && !ovf_new && !operation && !full;

	ctkvs_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ENTRIES * MAX_DIM)) u_vec_ram (
		.clk     (clk),
		.wr_en   (vec_we),
		.wr_addr ({entry_cnt_q[ENT_W-1:0], elem_cnt_q[DIM_W-1:0]}),
		.wr_data (element_value),
		.rd_en   (mac_re),
		.rd_addr ({e_q[ENT_W-1:0], i_q[DIM_W-1:0]}),
		.rd_data (vec_rd)
	);

	ctkvs_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_DIM)) u_query_ram (
		.clk     (clk),
		.wr_en   (q_we),
		.wr_addr (elem_cnt_q[DIM_W-1:0]),
		.wr_data (element_value),
		.rd_en   (mac_re),
		.rd_addr (i_q[DIM_W-1:0]),
		.rd_data (q_rd)
	);

	// entry length and collection
	ctkvs_ram #(.WIDTH(META_W), .DEPTH(MAX_ENTRIES)) u_meta_ram (
		.clk     (clk),
		.wr_en   (meta_we),
		.wr_addr (entry_cnt_q[ENT_W-1:0]),
		.wr_data ({len_new, collection_id}),
		.rd_en   (meta_re),
		.rd_addr (e_q[ENT_W-1:0]),
		.rd_data (meta_rd)
	);

	// one 16x16 multiplier, three products per element
	always_comb begin
		mul_a = $signed(q_rd);
		mul_b = $signed(vec_rd);
		case (state_q)
			ST_MAC_M1: begin
				mul_b = $signed(q_rd);
			end
			ST_MAC_M2: begin
				mul_a = $signed(vec_rd);
			end
			default: begin
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	assign mag     = dot_q[ACC_W-1] ? ACC_W'(-dot_q) : ACC_W'(dot_q);
	assign macc_nx = mb_q[0] ? macc_q + ma_q : macc_q;
	assign sat     = (x_q > ROOT_W'(SCORE_MAX)) ? ROOT_W'(SCORE_MAX) : x_q;

	// insertion point: slots scoring at least the new one stay ahead
	always_comb begin
		ins_pos = '0;
		for (int n = 0; n < MAX_K; n++) begin
			gt[n]   = (BC_W'(n) < bc_q) && (best_score_q[n] >= score_q);
			ins_pos = ins_pos + BC_W'(gt[n]);
		end
		ins_ok = ins_pos < k_q;
	end

	// next state and outputs
	always_comb begin
		state_d     = state_q;
		item_ready  = 1'b0;
		meta_re     = 1'b0;
		mac_re      = 1'b0;
		emit        = 1'b0;
		emit_last   = 1'b1;
		emit_status = STAT_NO_MATCH;
		emit_idx    = '0;
		emit_sim    = '0;
		case (state_q)
			ST_IDLE: begin
				item_ready = out_free;
				if (fire) begin
					if (!port_en_q) begin
						emit        = 1'b1;
						emit_status = STAT_DISABLED;
					end else if (last_element) begin
						if (ovf_new) begin
							emit        = 1'b1;
							emit_status = STAT_TOO_LONG;
						end else if (!operation) begin
							emit = 1'b1;
							if (full) begin
								emit_status = STAT_FULL;
							end else begin
								emit_status = STAT_INSERTED;
								emit_idx    = IDX_W'(entry_cnt_q);
							end
						end else begin
							state_d = ST_META;
						end
					end
				end
			end
			ST_META: begin
				if (e_q == entry_cnt_q || k_q == '0) begin
					state_d = ST_DONE;
				end else begin
					meta_re = 1'b1;
					state_d = ST_META_W;
				end
			end
			ST_META_W: begin
				if (meta_rd == {len_q, coll_q}) begin
					state_d = ST_MAC_RD;
				end else begin
					state_d = ST_META;
				end
			end
			ST_MAC_RD: begin
				mac_re  = 1'b1;
				state_d = ST_MAC_M0;
			end
			ST_MAC_M0: begin
				state_d = ST_MAC_M1;
			end
			ST_MAC_M1: begin
				state_d = ST_MAC_M2;
			end
			ST_MAC_M2: begin
				state_d = ST_MAC_M3;
			end
			ST_MAC_M3: begin
				state_d = (i_q + LEN_W'(1) == len_q) ? ST_NORM : ST_MAC_RD;
			end
			ST_NORM: begin
				state_d = (na_q == '0 || nb_q == '0) ? ST_INSERT : ST_MUL;
			end
			ST_MUL: begin
				if (mcnt_q == MC_W'(ACC_W - 1) && mphase_q) begin
					state_d = ST_ROOT_A;
				end
			end
			ST_ROOT_A: begin
				state_d = ST_ROOT_B;
			end
			ST_ROOT_B: begin
				state_d = (j_q == '0) ? ST_SCORE : ST_ROOT_A;
			end
			ST_SCORE: begin
				state_d = ST_INSERT;
			end
			ST_INSERT: begin
				state_d = ST_META;
			end
			ST_DONE: begin
				if (out_free) begin
					if (bc_q == '0) begin
						emit    = 1'b1;
						state_d = ST_IDLE;
					end else begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					emit        = 1'b1;
					emit_status = STAT_MATCH;
					emit_idx    = IDX_W'(best_idx_q[0]);
					emit_sim    = best_score_q[0];
					emit_last   = (bc_q == BC_W'(1));
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_en_q    <= 1'b0;
			entry_cnt_q  <= '0;
			elem_cnt_q   <= '0;
			ovf_q        <= 1'b0;
			bc_q         <= '0;
			result_valid <= 1'b0;
		end else begin
			if (cfg_write) begin
				port_en_q <= cfg_data;
			end
			if (fire) begin
				if (!port_en_q || last_element) begin
					elem_cnt_q <= '0;
					ovf_q      <= 1'b0;
				end else begin
					elem_cnt_q <= len_new;
					ovf_q      <= ovf_new;
				end
				if (port_en_q && last_element && operation) begin
					bc_q <= '0;
				end
			end
			if (meta_we) begin
				entry_cnt_q <= entry_cnt_q + CNT_W'(1);
			end
			if (state_q == ST_INSERT && ins_ok && bc_q < k_q) begin
				bc_q <= bc_q + BC_W'(1);
			end
			if (state_q == ST_EMIT && emit) begin
				bc_q <= bc_q - BC_W'(1);
			end
			if (emit) begin
				result_valid <= 1'b1;
			end else if (result_ready) begin
				result_valid <= 1'b0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (emit) begin
			status      <= emit_status;
			entry_index <= emit_idx;
			similarity  <= emit_sim;
			last_result <= emit_last;
		end
		case (state_q)
			ST_IDLE: begin
				if (fire) begin
					coll_q <= collection_id;
					len_q  <= len_new;
					k_q    <= (result_limit > K_W'(MAX_K)) ? BC_W'(MAX_K)
					                                        : BC_W'(result_limit);
					e_q    <= '0;
				end
			end
			ST_META_W: begin
				i_q   <= '0;
				dot_q <= '0;
				na_q  <= '0;
				nb_q  <= '0;
				if (meta_rd != {len_q, coll_q}) begin
					e_q <= e_q + CNT_W'(1);
				end
			end
			ST_MAC_M0: begin
				prod_q <= mul_p;
			end
			ST_MAC_M1: begin
				dot_q  <= dot_q + ACC_W'(prod_q);
				prod_q <= mul_p;
			end
			ST_MAC_M2: begin
				na_q   <= na_q + ACC_W'(prod_q);
				prod_q <= mul_p;
			end
			ST_MAC_M3: begin
				nb_q <= nb_q + ACC_W'(prod_q);
				i_q  <= i_q + LEN_W'(1);
			end
			ST_NORM: begin
				neg_q    <= dot_q[ACC_W-1];
				ma_q     <= PROD_W'(na_q);
				mb_q     <= nb_q;
				macc_q   <= '0;
				mcnt_q   <= '0;
				mphase_q <= 1'b0;
				score_q  <= '0;
			end
			ST_MUL: begin
				if (mcnt_q == MC_W'(ACC_W - 1)) begin
					if (!mphase_q) begin
						// P = na*nb done, start R = |dot|^2
						p_q      <= macc_nx;
						ma_q     <= PROD_W'(mag);
						mb_q     <= mag;
						macc_q   <= '0;
						mcnt_q   <= '0;
						mphase_q <= 1'b1;
					end else begin
						r_q  <= WIDE_W'(macc_nx) << RSH;
						s_q  <= '0;
						tj_q <= '0;
						pj_q <= WIDE_W'(p_q) << (2 * (ROOT_W - 1));
						x_q  <= '0;
						j_q  <= J_W'(ROOT_W - 1);
					end
				end else begin
					macc_q <= macc_nx;
					ma_q   <= ma_q << 1;
					mb_q   <= mb_q >> 1;
					mcnt_q <= mcnt_q + MC_W'(1);
				end
			end
			ST_ROOT_A: begin
				// (x + 2^j)^2 P = x^2 P + x P 2^(j+1) + P 2^(2j)
				cand_q <= s_q + tj_q + pj_q;
			end
			ST_ROOT_B: begin
				if (cand_q <= r_q) begin
					s_q      <= cand_q;
					x_q[j_q] <= 1'b1;
					tj_q     <= (tj_q + (pj_q << 1)) >> 1;
				end else begin
					tj_q <= tj_q >> 1;
				end
				pj_q <= pj_q >> 2;
				j_q  <= j_q - J_W'(1);
			end
			ST_SCORE: begin
				score_q <= neg_q ? -$signed(sat) : $signed(sat);
			end
			ST_INSERT: begin
				e_q <= e_q + CNT_W'(1);
				if (ins_ok) begin
					if (!gt[0]) begin
						best_idx_q[0]   <= ENT_W'(e_q);
						best_score_q[0] <= score_q;
					end
					for (int n = 1; n < MAX_K; n++) begin
						if (!gt[n] && gt[n-1]) begin
							best_idx_q[n]   <= ENT_W'(e_q);
							best_score_q[n] <= score_q;
						end else if (!gt[n]) begin
							best_idx_q[n]   <= best_idx_q[n-1];
							best_score_q[n] <= best_score_q[n-1];
						end
					end
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					for (int n = 0; n < MAX_K - 1; n++) begin
						best_idx_q[n]   <= best_idx_q[n+1];
						best_score_q[n] <= best_score_q[n+1];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// checks
	`CTKVS_ASSERT_NOW(a_ready_idle, item_ready, state_q == ST_IDLE,
		"input taken outside idle")
	`CTKVS_ASSERT_NOW(a_list_bound, state_q != ST_IDLE, bc_q <= k_q,
		"top-k list longer than k")
	`CTKVS_ASSERT_NOW(a_store_bound, 1'b1, entry_cnt_q <= CNT_W'(MAX_ENTRIES),
		"entry count past store size")
	`CTKVS_ASSERT_NEXT(a_emit_holds, emit && state_q == ST_EMIT && !emit_last,
		state_q == ST_EMIT && bc_q != '0, "result list ran dry")

endmodule
